@@ sv/i2cm_pkg.sv @@
package i2cm_pkg;

	// command codes on the mode field
	localparam logic [2:0] MODE_START     = 3'd0;
	localparam logic [2:0] MODE_WRITE     = 3'd1;
	localparam logic [2:0] MODE_READ_ACK  = 3'd2;
	localparam logic [2:0] MODE_READ_NACK = 3'd3;
	localparam logic [2:0] MODE_STOP      = 3'd4;

	// result slot codes
	localparam logic [2:0] SLOT_START   = 3'd0;
	localparam logic [2:0] SLOT_DATA    = 3'd1;
	localparam logic [2:0] SLOT_ACK     = 3'd2;
	localparam logic [2:0] SLOT_STOP    = 3'd3;
	localparam logic [2:0] SLOT_REFUSED = 3'd4;

	// bit slot counting within a byte command
	localparam int BIT_IDX_W = 3;
	localparam int BIT_CNT_W = 4;
	localparam logic [BIT_CNT_W-1:0] ACK_CNT = 4'd8;

	// command queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_W = 1;
	localparam int QUEUE_CNT_W = 2;

	typedef enum logic [2:0] {
		CMD_START,
		CMD_STOP,
		CMD_REFUSE,
		CMD_WRITE,
		CMD_READ
	} cmd_kind_t;

	// classified command: data is the tx byte for a write, rx byte for a read;
	// ack_bit is the sampled ack for a write, the answered level for a read
	typedef struct packed {
		cmd_kind_t   kind;
		logic [7:0]  data;
		logic        ack_bit;
	} cmd_desc_t;

	typedef struct packed {
		logic [2:0] slot;
		logic       sda_out;
		logic [7:0] rx_byte;
		logic       nack;
		logic       last;
	} res_beat_t;

	// result beat for bit slot cnt of a classified command
	function automatic res_beat_t beat_f(cmd_desc_t d, logic [BIT_CNT_W-1:0] cnt);
		res_beat_t b;
		logic      ack_slot;
		ack_slot  = (cnt == ACK_CNT);
		b.slot    = SLOT_REFUSED;
		b.sda_out = 1'b1;
		b.rx_byte = '0;
		b.nack    = 1'b0;
		b.last    = 1'b1;
		case (d.kind)
			CMD_START: begin
				b.slot    = SLOT_START;
				b.sda_out = 1'b0;
			end
			CMD_STOP: begin
				b.slot = SLOT_STOP;
			end
			CMD_WRITE: begin
				if (ack_slot) begin
					b.slot = SLOT_ACK;
					b.nack = d.ack_bit;
				end else begin
					b.slot    = SLOT_DATA;
					b.sda_out = d.data[~cnt[BIT_IDX_W-1:0]];
					b.last    = 1'b0;
				end
			end
			CMD_READ: begin
				if (ack_slot) begin
					b.slot    = SLOT_ACK;
					b.sda_out = d.ack_bit;
					b.rx_byte = d.data;
				end else begin
					b.slot = SLOT_DATA;
					b.last = 1'b0;
				end
			end
			default: begin
				b.slot = SLOT_REFUSED;
			end
		endcase
		return b;
	endfunction

endpackage

@@ sv/i2cm_if.sv @@
// command channel
interface i2cm_cmd_if;
	logic       valid;
	logic       ready;
	logic [2:0] mode;
	logic [7:0] data_byte;
	logic [8:0] line_levels;

	modport source (output valid, output mode, output data_byte, output line_levels,
		input ready);
	modport sink (input valid, input mode, input data_byte, input line_levels,
		output ready);
endinterface

// result channel
interface i2cm_res_if;
	logic       valid;
	logic       ready;
	logic [2:0] slot;
	logic       sda_out;
	logic [7:0] rx_byte;
	logic       nack;
	logic       last;

	modport source (output valid, output slot, output sda_out, output rx_byte,
		output nack, output last, input ready);
	modport sink (input valid, input slot, input sda_out, input rx_byte,
		input nack, input last, output ready);
endinterface

@@ sv/i2cm_front.sv @@
module i2cm_front (
	input  logic              clk,
	input  logic              arst_n,
	i2cm_cmd_if.sink          cmd,
	output logic              push_valid,
	input  logic              push_ready,
	output i2cm_pkg::cmd_desc_t push_desc
);
	import i2cm_pkg::*;

	logic in_trans_q;
	logic failed_q;
	logic in_trans_d;
	logic failed_d;
	logic accept;

	assign cmd.ready  = push_ready;
	assign push_valid = cmd.valid;
	assign accept     = cmd.valid && push_ready;

	// classify the command and work out the next bus state
	always_comb begin
		push_desc.kind    = CMD_REFUSE;
		push_desc.data    = cmd.data_byte;
		push_desc.ack_bit = cmd.line_levels[0];
		in_trans_d        = in_trans_q;
		failed_d          = failed_q;
		case (cmd.mode)
			MODE_START: begin
				push_desc.kind = CMD_START;
				in_trans_d     = 1'b1;
				failed_d       = 1'b0;
			end
			MODE_STOP: begin
				push_desc.kind = CMD_STOP;
				in_trans_d     = 1'b0;
				failed_d       = 1'b0;
			end
			MODE_WRITE: begin
				if (in_trans_q && !failed_q) begin
					push_desc.kind = CMD_WRITE;
					failed_d       = cmd.line_levels[0];
				end
			end
			MODE_READ_ACK, MODE_READ_NACK: begin
				if (in_trans_q && !failed_q) begin
					push_desc.kind    = CMD_READ;
					push_desc.data    = cmd.line_levels[8:1];
					push_desc.ack_bit = (cmd.mode == MODE_READ_NACK);
				end
			end
			default: begin
				push_desc.kind = CMD_REFUSE;
			end
		endcase
	end

	// bus state, updated on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_trans_q <= 1'b0;
			failed_q   <= 1'b0;
		end else if (accept) begin
			in_trans_q <= in_trans_d;
			failed_q   <= failed_d;
		end
	end

endmodule

@@ sv/i2cm_queue.sv @@
module i2cm_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_valid,
	output logic                push_ready,
	input  i2cm_pkg::cmd_desc_t push_desc,
	output logic                pop_valid,
	input  logic                pop_ready,
	output i2cm_pkg::cmd_desc_t pop_desc
);
	import i2cm_pkg::*;

	cmd_desc_t                entry_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0]   wr_ptr_q;
	logic [QUEUE_PTR_W-1:0]   rd_ptr_q;
	logic [QUEUE_CNT_W-1:0]   count_q;
	logic                     do_push;
	logic                     do_pop;

	assign push_ready = (count_q != QUEUE_CNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_desc   = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_desc;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ sv/i2cm_back.sv @@
module i2cm_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pop_valid,
	output logic                pop_ready,
	input  i2cm_pkg::cmd_desc_t pop_desc,
	i2cm_res_if.source          res
);
	import i2cm_pkg::*;

	cmd_desc_t              cur_q;
	logic                   busy_q;
	logic [BIT_CNT_W-1:0]   cnt_q;
	res_beat_t              res_q;
	logic                   res_valid_q;

	cmd_desc_t              src;
	logic [BIT_CNT_W-1:0]   src_cnt;
	res_beat_t              beat;
	logic                   out_ok;
	logic                   emit;

	// next beat comes from the command in progress or straight from the queue head
	assign out_ok    = !res_valid_q || res.ready;
	assign src       = busy_q ? cur_q : pop_desc;
	assign src_cnt   = busy_q ? cnt_q : '0;
	assign beat      = beat_f(src, src_cnt);
	assign emit      = out_ok && (busy_q || pop_valid);
	assign pop_ready = !busy_q && out_ok;

	// command in progress and its slot counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (emit) begin
			busy_q <= !beat.last;
			cnt_q  <= src_cnt + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (emit && !busy_q) begin
			cur_q <= pop_desc;
		end
	end

	// result output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (emit) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_q <= beat;
		end
	end

	assign res.valid   = res_valid_q;
	assign res.slot    = res_q.slot;
	assign res.sda_out = res_q.sda_out;
	assign res.rx_byte = res_q.rx_byte;
	assign res.nack    = res_q.nack;
	assign res.last    = res_q.last;

endmodule

@@ sv/i2c_master_byte_engine.sv @@
// I2C master byte engine. Each command beat (start, write byte, read byte with
// ACK or NACK, stop) turns into bit-slot result beats: one for a start, a stop or
// a refused command, nine for a byte (eight data slots MSB first, then the ack
// slot). The result register sends one beat per clock while the receiver is
// ready. Commands are classified on entry and held in a two-entry queue, so
// new commands are taken while earlier ones are still being sent. After a
// NACKed write, byte commands are refused until the next start; a stop may be
// issued at any time.
module i2c_master_byte_engine (
	input  logic       clk,
	input  logic       arst_n,
	i2cm_cmd_if.sink   cmd,
	i2cm_res_if.source res
);
	import i2cm_pkg::*;

	logic      push_valid;
	logic      push_ready;
	cmd_desc_t push_desc;
	logic      pop_valid;
	logic      pop_ready;
	cmd_desc_t pop_desc;

	// command classification and bus state
	i2cm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_desc  (push_desc)
	);

	// decoupling queue
	i2cm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_desc  (push_desc),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_desc   (pop_desc)
	);

	// bit slot sequencing
	i2cm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_desc  (pop_desc),
		.res       (res)
	);

endmodule

@@ sv/i2cm_checker.sv @@
module i2cm_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_ready,
	input logic [2:0] slot,
	input logic       sda_out,
	input logic [7:0] rx_byte,
	input logic       nack,
	input logic       last
);
	import i2cm_pkg::*;

	logic [BIT_CNT_W-1:0] data_cnt_q;
	logic                 res_acc;

	assign res_acc = res_valid && res_ready;

	// data slots seen since the last final beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_cnt_q <= '0;
		end else if (res_acc) begin
			if (last) begin
				data_cnt_q <= '0;
			end else if (slot == SLOT_DATA && data_cnt_q != ACK_CNT) begin
				data_cnt_q <= data_cnt_q + 1'b1;
			end
		end
	end

	// an ack slot closes exactly eight data slots
	a_ack_after_eight: assert property (@(posedge clk) disable iff (!arst_n)
		res_acc && slot == SLOT_ACK |-> data_cnt_q == ACK_CNT && last)
		else $error("ack slot not after eight data slots");

	// no more than eight data slots in a byte
	a_data_bound: assert property (@(posedge clk) disable iff (!arst_n)
		res_acc && slot == SLOT_DATA |-> data_cnt_q < ACK_CNT && !last)
		else $error("data slot out of place");

	// single-slot commands are final and carry no rx or nack
	a_single_final: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (slot == SLOT_START || slot == SLOT_STOP || slot == SLOT_REFUSED)
		|-> last && rx_byte == '0 && nack == 1'b0)
		else $error("single slot beat malformed");

	// a stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(slot) && $stable(sda_out)
		&& $stable(rx_byte) && $stable(nack) && $stable(last))
		else $error("stalled result changed");

endmodule

bind i2c_master_byte_engine i2cm_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.slot      (res.slot),
	.sda_out   (res.sda_out),
	.rx_byte   (res.rx_byte),
	.nack      (res.nack),
	.last      (res.last)
);

@@ dv/tb.sv @@
`timescale 1ns / 1ps

module tb;
	import i2cm_pkg::*;

	// mode codes the block treats as undefined
	localparam logic [2:0] MODE_RSVD_5 = 3'd5;
	localparam logic [2:0] MODE_RSVD_6 = 3'd6;
	localparam logic [2:0] MODE_RSVD_7 = 3'd7;

	localparam int LONG_STALL_CYCLES = 80;
	localparam int TAIL_CYCLES       = 20;
	localparam int MAX_PRINTED_ERRS  = 40;

	typedef struct {
		logic [2:0] mode;
		logic [7:0] data_byte;
		logic [8:0] line_levels;
	} i2c_cmd_t;

	logic clk;
	logic arst_n;

	i2cm_cmd_if cmd_bus ();
	i2cm_res_if res_bus ();

	i2c_master_byte_engine u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_bus),
		.res    (res_bus)
	);

	i2c_cmd_t  pending_cmds[$];
	res_beat_t expected_beats[$];

	// bus state as the host sees it
	bit bus_open;
	bit nack_latched;

	int cmd_issued;
	int cmd_accepted;
	int queued_items;
	int send_idle_pct;
	int recv_idle_pct;
	int rx_stall_left;
	int mismatch_cnt;
	int beats_seen;
	int start_beats, stop_beats, ack_beats, refused_beats, nack_beats;

	always #5 clk = ~clk;

	task automatic report_mismatch(input string msg);
		if (mismatch_cnt < MAX_PRINTED_ERRS)
			$display("ERROR at %0t: %s", $realtime, msg);
		mismatch_cnt++;
	endtask

	function automatic void push_beat(logic [2:0] slot, logic sda, logic [7:0] rx,
		logic nk, logic lst);
		res_beat_t b;
		b.slot    = slot;
		b.sda_out = sda;
		b.rx_byte = rx;
		b.nack    = nk;
		b.last    = lst;
		expected_beats.push_back(b);
	endfunction

	// expected bit slots of one accepted command, updates bus state
	task automatic predict_slots(input logic [2:0] mode, input logic [7:0] tx,
		input logic [8:0] lines);
		int i;
		case (mode)
			MODE_START: begin
				push_beat(SLOT_START, 1'b0, 8'h00, 1'b0, 1'b1);
				bus_open     = 1'b1;
				nack_latched = 1'b0;
			end
			MODE_STOP: begin
				push_beat(SLOT_STOP, 1'b1, 8'h00, 1'b0, 1'b1);
				bus_open     = 1'b0;
				nack_latched = 1'b0;
			end
			default: begin
				if (mode > MODE_STOP || nack_latched || !bus_open) begin
					push_beat(SLOT_REFUSED, 1'b1, 8'h00, 1'b0, 1'b1);
				end else if (mode == MODE_WRITE) begin
					for (i = 0; i < 8; i++)
						push_beat(SLOT_DATA, tx[7-i], 8'h00, 1'b0, 1'b0);
					push_beat(SLOT_ACK, 1'b1, 8'h00, lines[0], 1'b1);
					if (lines[0])
						nack_latched = 1'b1;
				end else begin
					for (i = 0; i < 8; i++)
						push_beat(SLOT_DATA, 1'b1, 8'h00, 1'b0, 1'b0);
					push_beat(SLOT_ACK, mode == MODE_READ_NACK, lines[8:1], 1'b0, 1'b1);
				end
			end
		endcase
	endtask

	function automatic void queue_cmd(logic [2:0] mode, logic [7:0] data,
		logic [8:0] lines);
		i2c_cmd_t c;
		c.mode        = mode;
		c.data_byte   = data;
		c.line_levels = lines;
		pending_cmds.push_back(c);
		queued_items++;
	endfunction

	// line levels with the ack slot nacked one time in n
	function automatic logic [8:0] rand_lines(int n);
		logic [8:0] l;
		l    = 9'($urandom);
		l[0] = ($urandom_range(0, n - 1) == 0);
		return l;
	endfunction

	// one well formed transfer: start, address, a few bytes, mostly a stop
	task automatic queue_transaction();
		int nbytes;
		int k;
		nbytes = $urandom_range(1, 4);
		queue_cmd(MODE_START, 8'($urandom), 9'($urandom));
		queue_cmd(MODE_WRITE, 8'($urandom), rand_lines(10));
		for (k = 0; k < nbytes; k++) begin
			case ($urandom_range(0, 5))
				0, 1, 2: queue_cmd(MODE_WRITE, 8'($urandom), rand_lines(12));
				3, 4:    queue_cmd(MODE_READ_ACK, 8'($urandom), 9'($urandom));
				default: begin
					queue_cmd(MODE_START, 8'($urandom), 9'($urandom));
					queue_cmd(MODE_WRITE, 8'($urandom), rand_lines(10));
				end
			endcase
		end
		if ($urandom_range(0, 1) == 0)
			queue_cmd(MODE_READ_NACK, 8'($urandom), 9'($urandom));
		if ($urandom_range(0, 9) != 0)
			queue_cmd(MODE_STOP, 8'($urandom), 9'($urandom));
	endtask

	task automatic queue_random(input int count);
		int target;
		target = queued_items + count;
		while (queued_items < target) begin
			if ($urandom_range(0, 9) == 0)
				queue_cmd(3'($urandom_range(0, 7)), 8'($urandom), 9'($urandom));
			else
				queue_transaction();
		end
	endtask

	// sender holds back until every beat it caused has come out
	task automatic wait_drained();
		@(negedge clk);
		while (pending_cmds.size() != 0 || cmd_accepted != cmd_issued ||
			expected_beats.size() != 0)
			@(negedge clk);
	endtask

	// command driver
	always @(negedge clk) begin
		i2c_cmd_t c;
		if (!arst_n) begin
			cmd_bus.valid <= 1'b0;
		end else if (cmd_accepted == cmd_issued) begin
			if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				c = pending_cmds.pop_front();
				cmd_bus.valid       <= 1'b1;
				cmd_bus.mode        <= c.mode;
				cmd_bus.data_byte   <= c.data_byte;
				cmd_bus.line_levels <= c.line_levels;
				cmd_issued++;
			end else begin
				cmd_bus.valid <= 1'b0;
			end
		end
	end

	// result receiver, long stalls counted down here
	always @(negedge clk) begin
		if (rx_stall_left > 0) begin
			rx_stall_left--;
			res_bus.ready <= 1'b0;
		end else begin
			res_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// monitor: check result beats, predict from accepted command beats
	always @(posedge clk) begin
		res_beat_t want;
		if (arst_n) begin
			if (res_bus.valid && res_bus.ready) begin
				beats_seen++;
				case (res_bus.slot)
					SLOT_START:   start_beats++;
					SLOT_STOP:    stop_beats++;
					SLOT_ACK:     ack_beats++;
					SLOT_REFUSED: refused_beats++;
					default: ;
				endcase
				if (res_bus.nack === 1'b1)
					nack_beats++;
				if (expected_beats.size() == 0) begin
					report_mismatch($sformatf("result beat with none expected, slot %0d",
						res_bus.slot));
				end else begin
					want = expected_beats.pop_front();
					if (res_bus.slot !== want.slot)
						report_mismatch($sformatf("slot got %0d want %0d",
							res_bus.slot, want.slot));
					if (res_bus.sda_out !== want.sda_out)
						report_mismatch($sformatf("sda_out got %b want %b",
							res_bus.sda_out, want.sda_out));
					if (res_bus.rx_byte !== want.rx_byte)
						report_mismatch($sformatf("rx_byte got %h want %h",
							res_bus.rx_byte, want.rx_byte));
					if (res_bus.nack !== want.nack)
						report_mismatch($sformatf("nack got %b want %b",
							res_bus.nack, want.nack));
					if (res_bus.last !== want.last)
						report_mismatch($sformatf("last got %b want %b",
							res_bus.last, want.last));
				end
			end
			if (cmd_bus.valid && cmd_bus.ready) begin
				predict_slots(cmd_bus.mode, cmd_bus.data_byte, cmd_bus.line_levels);
				cmd_accepted++;
			end
		end
	end

	initial begin
		clk                 = 1'b0;
		arst_n              = 1'b0;
		cmd_bus.valid       = 1'b0;
		cmd_bus.mode        = MODE_START;
		cmd_bus.data_byte   = 8'h00;
		cmd_bus.line_levels = 9'h000;
		res_bus.ready       = 1'b0;
		rx_stall_left       = 0;
		send_idle_pct       = 17;
		recv_idle_pct       = 51;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: refusals while idle, byte extremes, nack lockout, stops
		queue_cmd(MODE_STOP, 8'h00, 9'h000);
		queue_cmd(MODE_WRITE, 8'hff, 9'h000);
		queue_cmd(MODE_READ_ACK, 8'h00, 9'h1ff);
		queue_cmd(MODE_RSVD_5, 8'hff, 9'h1ff);
		queue_cmd(MODE_RSVD_6, 8'h00, 9'h000);
		queue_cmd(MODE_RSVD_7, 8'h55, 9'h0aa);
		queue_cmd(MODE_START, 8'h00, 9'h000);
		queue_cmd(MODE_WRITE, 8'h00, 9'h1fe);
		queue_cmd(MODE_WRITE, 8'hff, 9'h000);
		queue_cmd(MODE_READ_ACK, 8'h00, 9'h1ff);
		queue_cmd(MODE_READ_NACK, 8'hff, 9'h000);
		queue_cmd(MODE_RSVD_7, 8'hff, 9'h1ff);
		queue_cmd(MODE_WRITE, 8'ha5, 9'h001);
		queue_cmd(MODE_WRITE, 8'h3c, 9'h000);
		queue_cmd(MODE_READ_ACK, 8'h00, 9'h000);
		queue_cmd(MODE_START, 8'hff, 9'h1ff);
		queue_cmd(MODE_WRITE, 8'h5a, 9'h0aa);
		queue_cmd(MODE_READ_NACK, 8'h00, 9'h155);
		queue_cmd(MODE_STOP, 8'hff, 9'h1ff);
		queue_cmd(MODE_STOP, 8'h00, 9'h000);
		queue_cmd(MODE_READ_NACK, 8'h00, 9'h1ff);
		queue_cmd(MODE_START, 8'h00, 9'h000);
		queue_cmd(MODE_WRITE, 8'h81, 9'h1ff);
		queue_cmd(MODE_STOP, 8'h00, 9'h000);
		queue_cmd(MODE_READ_ACK, 8'hff, 9'h1ff);

		// phase one with a long receiver hold-off while commands keep coming
		queue_random(160);
		@(posedge clk);
		rx_stall_left = LONG_STALL_CYCLES;
		wait_drained();

		send_idle_pct = 51;
		recv_idle_pct = 17;
		queue_random(160);
		wait_drained();

		// full rate, with a pause for the block to empty halfway
		send_idle_pct = 0;
		recv_idle_pct = 0;
		queue_random(80);
		wait_drained();
		queue_random(80);
		wait_drained();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_beats.size() != 0)
			report_mismatch($sformatf("%0d result beats never arrived",
				expected_beats.size()));

		$display("%0d commands gave %0d result beats: %0d start, %0d stop, %0d ack",
			cmd_accepted, beats_seen, start_beats, stop_beats, ack_beats);
		$display("%0d refused commands, %0d nacked writes, %0d mismatches",
			refused_beats, nack_beats, mismatch_cnt);
		if (mismatch_cnt == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// run limit
	initial begin
		#2000000;
		$display("Verification failed");
		$finish;
	end

endmodule
